@@ rtl/core/jfs_pkg.sv @@
`default_nettype none

package jfs_pkg;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USER_W = 3;
   localparam int MARKER_W   = 8;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
   localparam logic [32:0] FRAME_OVERHEAD = 33'd9;

   localparam logic REQ_DATA = 1'b0;
   localparam logic REQ_EOS  = 1'b1;

   typedef enum logic [1:0] {
      PH_LEN,
      PH_BODY,
      PH_CRC,
      PH_MARK
   } phase_type;

   typedef enum logic [2:0] {
      OC_OK,
      OC_INCOMPLETE,
      OC_CRC_FAIL,
      OC_BAD_MARKER,
      OC_SCAN_END
   } outcome_type;

   typedef struct packed {
      outcome_type outcome;
      logic [31:0] frame_offset;
      logic [32:0] frame_bytes;
      logic [31:0] good_frames;
      logic        last_of_run;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/journal_frame_scanner.sv @@
`default_nettype none

// Journal frame scanner. Takes one journal byte (or an end-of-stream marker) per
// cycle and checks length-prefixed frames: 4-byte LE length, body, 4-byte LE
// CRC-32 of the body, commit marker byte. A byte is fully processed in the
// cycle it is accepted; its result, if any, is registered into the result queue.
// Results go through a 4-entry queue; req_tready is low while fewer than two
// entries are free, since end of stream in mid-frame yields two results
// (INCOMPLETE then SCAN END) that drain at one per cycle. Sustained rate is one
// byte per cycle as long as the result side keeps up. After CRC failure or a
// bad marker, bytes are dropped until end of stream; end of stream always
// returns the scanner to offset 0 with a zero good-frame count.
module journal_frame_scanner (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [jfs_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  wire logic                           req_tuser,   // [0] req_type

   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [jfs_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [31:0] frame_offset,
                                                            // [64:32] frame_bytes,
                                                            // [96:65] good_frames,
                                                            // [103:97] zero
   output      logic [jfs_pkg::RSP_USER_W-1:0] rsp_tuser,   // [2:0] outcome
   output      logic                           rsp_tlast,   // last_of_run

   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [jfs_pkg::MARKER_W-1:0]   csr_data     // commit_marker
);

   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ jfs_pkg::CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [31:0] put_lane(input logic [31:0] v, input logic [7:0] b,
                                            input logic [1:0] idx);
      return v | ({24'd0, b} << {idx, 3'b000});
   endfunction

   logic [jfs_pkg::MARKER_W-1:0] marker_ff;

   jfs_pkg::phase_type phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] check_ff, check_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] good_ff, good_in;
   logic        halted_ff, halted_in;

   jfs_pkg::result_type fifo_ff [jfs_pkg::FIFO_DEPTH];
   logic [jfs_pkg::FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [jfs_pkg::FIFO_CW-1:0] fill_ff, fill_in;

   jfs_pkg::result_type res0, res1;
   logic [1:0]  push_n;
   logic        req_fire, pop, is_eos;
   logic [7:0]  byte_w;
   logic [31:0] count_inc, length_w, check_w;
   logic [32:0] size_w;

   assign req_fire  = req_tvalid && req_tready;
   assign pop       = rsp_tvalid && rsp_tready;
   assign is_eos    = (req_tuser == jfs_pkg::REQ_EOS);
   assign byte_w    = req_tdata[7:0];
   assign count_inc = count_ff + 32'd1;
   assign length_w  = put_lane(length_ff, byte_w, count_ff[1:0]);
   assign check_w   = put_lane(check_ff, byte_w, count_ff[1:0]);
   assign size_w    = {1'b0, length_ff} + jfs_pkg::FRAME_OVERHEAD;

   assign req_tready = (fill_ff <= jfs_pkg::FIFO_CW'(jfs_pkg::FIFO_DEPTH - 2));
   assign csr_ready  = 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      crc_in    = crc_ff;
      check_in  = check_ff;
      start_in  = start_ff;
      good_in   = good_ff;
      halted_in = halted_ff;
      push_n    = 2'd0;
      res0      = '{outcome: jfs_pkg::OC_SCAN_END, frame_offset: start_ff,
                    frame_bytes: '0, good_frames: good_ff, last_of_run: 1'b1};
      res1      = res0;

      if (req_fire) begin
         if (is_eos) begin
            if (!halted_ff && (phase_ff != jfs_pkg::PH_LEN || count_ff != '0)) begin
               res0.outcome     = jfs_pkg::OC_INCOMPLETE;
               res0.last_of_run = 1'b0;
               push_n           = 2'd2;
            end else begin
               push_n = 2'd1;
            end
            phase_in  = jfs_pkg::PH_LEN;
            count_in  = '0;
            length_in = '0;
            crc_in    = jfs_pkg::CRC_INIT;
            check_in  = '0;
            start_in  = '0;
            good_in   = '0;
            halted_in = 1'b0;
         end else if (!halted_ff) begin
            unique case (phase_ff)
               jfs_pkg::PH_LEN: begin
                  length_in = length_w;
                  count_in  = count_inc;
                  if (count_ff[1:0] == 2'd3) begin
                     count_in = '0;
                     crc_in   = jfs_pkg::CRC_INIT;
                     check_in = '0;
                     phase_in = (length_w == '0) ? jfs_pkg::PH_CRC : jfs_pkg::PH_BODY;
                  end
               end
               jfs_pkg::PH_BODY: begin
                  crc_in   = crc_step(crc_ff, byte_w);
                  count_in = count_inc;
                  if (count_inc == length_ff) begin
                     count_in = '0;
                     phase_in = jfs_pkg::PH_CRC;
                  end
               end
               jfs_pkg::PH_CRC: begin
                  check_in = check_w;
                  count_in = count_inc;
                  if (count_ff[1:0] == 2'd3) begin
                     count_in = '0;
                     if (check_w != ~crc_ff) begin
                        res0.outcome = jfs_pkg::OC_CRC_FAIL;
                        push_n       = 2'd1;
                        halted_in    = 1'b1;
                     end else begin
                        phase_in = jfs_pkg::PH_MARK;
                     end
                  end
               end
               jfs_pkg::PH_MARK: begin
                  push_n = 2'd1;
                  if (byte_w != marker_ff) begin
                     res0.outcome = jfs_pkg::OC_BAD_MARKER;
                     halted_in    = 1'b1;
                  end else begin
                     good_in          = (good_ff == '1) ? good_ff : good_ff + 32'd1;
                     res0.outcome     = jfs_pkg::OC_OK;
                     res0.frame_bytes = size_w;
                     res0.good_frames = good_in;
                     start_in         = start_ff + size_w[31:0];
                     phase_in         = jfs_pkg::PH_LEN;
                     count_in         = '0;
                     length_in        = '0;
                     check_in         = '0;
                     crc_in           = jfs_pkg::CRC_INIT;
                  end
               end
            endcase
         end
      end

      fill_in = fill_ff + jfs_pkg::FIFO_CW'(push_n) - jfs_pkg::FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= '0;
         phase_ff  <= jfs_pkg::PH_LEN;
         count_ff  <= '0;
         length_ff <= '0;
         crc_ff    <= jfs_pkg::CRC_INIT;
         check_ff  <= '0;
         start_ff  <= '0;
         good_ff   <= '0;
         halted_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            marker_ff <= csr_data;
         end
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         crc_ff    <= crc_in;
         check_ff  <= check_in;
         start_ff  <= start_in;
         good_ff   <= good_in;
         halted_ff <= halted_in;
         wr_ptr_ff <= wr_ptr_ff + jfs_pkg::FIFO_AW'(push_n);
         rd_ptr_ff <= rd_ptr_ff + jfs_pkg::FIFO_AW'(pop);
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + jfs_pkg::FIFO_AW'(1)] <= res1;
      end
   end

   jfs_pkg::result_type head;
   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tuser  = head.outcome;
   assign rsp_tlast  = head.last_of_run;
   assign rsp_tdata  = {7'd0, head.good_frames, head.frame_bytes, head.frame_offset};

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= jfs_pkg::FIFO_CW'(jfs_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_eos) |=> (start_ff == '0 && good_ff == '0 && !halted_ff
                                && phase_ff == jfs_pkg::PH_LEN && count_ff == '0))
      else $error("stream state not cleared at end of stream");

   a_halted_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_eos && halted_ff) |-> (push_n == 2'd0))
      else $error("result produced while halted");

   a_ok_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && head.outcome == jfs_pkg::OC_OK) |-> (head.frame_bytes >= 33'd9))
      else $error("ok frame with short size");

   a_fail_halts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_eos && push_n == 2'd1 && res0.outcome != jfs_pkg::OC_OK)
      |=> halted_ff)
      else $error("failure did not halt scan");
`endif

endmodule

`default_nettype wire

@@ bench/journal_frame_scanner_test.sv @@
module journal_frame_scanner_test;
   timeunit 1ns;
   timeprecision 1ps;

   import jfs_pkg::*;

   typedef struct {
      logic       kind;
      logic [7:0] value;
   } journal_item;

   typedef enum int {
      INTACT,
      BAD_CHECK,
      BAD_COMMIT,
      CUT_SHORT
   } frame_flaw;

   logic                  clock;
   logic                  reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [7:0] data_byte
   logic                  req_tuser = 1'b0; // [0] req_type

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [31:0] frame_offset, [64:32] frame_bytes,
                                            // [96:65] good_frames, [103:97] zero
   logic [RSP_USER_W-1:0] rsp_tuser;        // [2:0] outcome
   logic                  rsp_tlast;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [MARKER_W-1:0]   csr_data = '0;

   journal_frame_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   journal_item journal_q[$];
   result_type  due_results[$];
   int          fed_items = 0;
   int          mismatches = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   logic        steady = 1'b0;

   // scanner state as the bench sees it
   logic [7:0]  commit_byte;
   phase_type   ph;
   logic [31:0] fcount;
   logic [31:0] blen;
   logic [31:0] crc;
   logic [31:0] chk;
   logic [31:0] soff;
   logic [31:0] okcnt;
   logic        stopped;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("end of test: mismatches");
      $finish;
   end

   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] v;
      v = c ^ {24'h0, b};
      for (int i = 0; i < 8; i++)
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      return v;
   endfunction

   function automatic void clear_stream();
      ph      = PH_LEN;
      fcount  = '0;
      blen    = '0;
      crc     = CRC_INIT;
      chk     = '0;
      soff    = '0;
      okcnt   = '0;
      stopped = 1'b0;
   endfunction

   function automatic void queue_result(input outcome_type oc, input logic [32:0] size,
                                        input logic last);
      result_type r;
      r.outcome      = oc;
      r.frame_offset = soff;
      r.frame_bytes  = size;
      r.good_frames  = okcnt;
      r.last_of_run  = last;
      due_results.push_back(r);
   endfunction

   function automatic void predict_item(input journal_item it);
      logic [32:0] size;
      if (it.kind == REQ_EOS) begin
         if (!stopped && (ph != PH_LEN || fcount != 0))
            queue_result(OC_INCOMPLETE, '0, 1'b0);
         queue_result(OC_SCAN_END, '0, 1'b1);
         clear_stream();
         return;
      end
      if (stopped)
         return;
      case (ph)
         PH_LEN: begin
            blen = blen | ({24'h0, it.value} << (fcount[1:0] * 8));
            fcount++;
            if (fcount >= 4) begin
               fcount = '0;
               crc    = CRC_INIT;
               chk    = '0;
               ph     = (blen == 0) ? PH_CRC : PH_BODY;
            end
         end
         PH_BODY: begin
            crc = crc_step(crc, it.value);
            fcount++;
            if (fcount == blen) begin
               fcount = '0;
               ph     = PH_CRC;
            end
         end
         PH_CRC: begin
            chk = chk | ({24'h0, it.value} << (fcount[1:0] * 8));
            fcount++;
            if (fcount >= 4) begin
               fcount = '0;
               if (chk != ~crc) begin
                  queue_result(OC_CRC_FAIL, '0, 1'b1);
                  stopped = 1'b1;
               end else begin
                  ph = PH_MARK;
               end
            end
         end
         default: begin
            if (it.value != commit_byte) begin
               queue_result(OC_BAD_MARKER, '0, 1'b1);
               stopped = 1'b1;
            end else begin
               size = {1'b0, blen} + FRAME_OVERHEAD;
               if (okcnt != 32'hFFFF_FFFF)
                  okcnt++;
               queue_result(OC_OK, size, 1'b1);
               soff   = soff + size[31:0];
               ph     = PH_LEN;
               fcount = '0;
               blen   = '0;
               chk    = '0;
               crc    = CRC_INIT;
            end
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(99, 0);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic void check_field(input string name, input logic [32:0] want,
                                       input logic [32:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // driver
   always @(posedge clock) begin : feed
      logic fire;
      logic hold;
      fire = req_tvalid && req_tready;
      if (fire)
         predict_item(journal_q.pop_front());
      hold = req_tvalid && !fire;
      if (!hold && !reset) begin
         if (req_gap != 0) begin
            req_gap--;
         end else if (journal_q.size() != 0) begin
            hold    = 1'b1;
            req_gap = pick_gap();
         end
      end
      req_tvalid <= hold;
      if (hold) begin
         req_tdata <= journal_q[0].value;
         req_tuser <= journal_q[0].kind;
      end
   end

   // result side backpressure
   always @(posedge clock) begin : sink
      if (rsp_gap != 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_tvalid && rsp_tready)
            rsp_gap = pick_gap();
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            $error("unexpected transaction: outcome %0d offset %0d", rsp_tuser, rsp_tdata[31:0]);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            check_field("outcome", want.outcome, rsp_tuser);
            check_field("frame_offset", want.frame_offset, rsp_tdata[31:0]);
            check_field("frame_bytes", want.frame_bytes, rsp_tdata[64:32]);
            check_field("good_frames", want.good_frames, rsp_tdata[96:65]);
            check_field("last_of_run", want.last_of_run, rsp_tlast);
         end
      end
   end

   task automatic push_item(input logic kind, input logic [7:0] value);
      journal_q.push_back('{kind: kind, value: value});
      fed_items++;
   endtask

   task automatic add_frame(input logic [31:0] len, input frame_flaw flaw);
      logic [7:0]  bytes_q[$];
      logic [7:0]  b;
      logic [31:0] c;
      logic [31:0] sum;
      int          cut;
      c = CRC_INIT;
      for (int i = 0; i < 4; i++)
         bytes_q.push_back(len[8*i +: 8]);
      for (int unsigned i = 0; i < len; i++) begin
         b = 8'($urandom_range(255, 0));
         bytes_q.push_back(b);
         c = crc_step(c, b);
      end
      sum = ~c;
      if (flaw == BAD_CHECK)
         sum = sum ^ (32'h1 << $urandom_range(31, 0));
      for (int i = 0; i < 4; i++)
         bytes_q.push_back(sum[8*i +: 8]);
      if (flaw == BAD_COMMIT)
         bytes_q.push_back(commit_byte ^ 8'($urandom_range(255, 1)));
      else
         bytes_q.push_back(commit_byte);
      cut = (flaw == CUT_SHORT) ? $urandom_range(bytes_q.size() - 1, 1) : bytes_q.size();
      for (int i = 0; i < cut; i++)
         push_item(REQ_DATA, bytes_q[i]);
   endtask

   function automatic logic [31:0] pick_len();
      int r;
      r = $urandom_range(99, 0);
      if (r < 5)
         return $urandom_range(300, 40);
      if (r < 15)
         return 0;
      return $urandom_range(16, 1);
   endfunction

   task automatic add_stream();
      int        frames;
      int        roll;
      frame_flaw flaw;
      frames = $urandom_range(4, 1);
      roll   = $urandom_range(99, 0);
      flaw   = INTACT;
      if (roll < 8) begin
         // garbage: length field is whatever comes first
         repeat ($urandom_range(12, 1))
            push_item(REQ_DATA, 8'($urandom_range(255, 0)));
      end else begin
         for (int i = 0; i < frames; i++) begin
            if (i == frames - 1 && roll >= 50)
               flaw = frame_flaw'($urandom_range(3, 1));
            add_frame(pick_len(), flaw);
         end
         // bytes after a failure are dropped by the scanner
         if (flaw == BAD_CHECK || flaw == BAD_COMMIT)
            repeat ($urandom_range(6, 0))
               journal_q.push_back('{kind: REQ_DATA, value: 8'($urandom_range(255, 0))});
      end
      push_item(REQ_EOS, 8'($urandom_range(255, 0)));
   endtask

   task automatic wait_drained();
      while (journal_q.size() != 0 || due_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_marker(input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      commit_byte = v;
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0] markers[5];
      int         target;
      commit_byte = 8'h00;
      clear_stream();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // clean end on an empty stream, zero-length and one-byte frames, cut length field
      push_item(REQ_EOS, 8'hFF);
      add_frame(32'd0, INTACT);
      add_frame(32'd1, INTACT);
      push_item(REQ_DATA, 8'hFF);
      push_item(REQ_DATA, 8'hFF);
      push_item(REQ_EOS, 8'h00);
      wait_drained();

      markers = '{8'hFF, 8'($urandom_range(254, 1)), 8'h00, 8'($urandom_range(254, 1)), 8'h80};
      target  = fed_items;
      for (int p = 0; p < 5; p++) begin
         write_marker(markers[p]);
         steady = (p == 2) || ($urandom_range(3, 0) == 0);
         target += 250;
         while (fed_items < target)
            add_stream();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (due_results.size() != 0) begin
         $error("%0d expected results never arrived", due_results.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
